### design/bnf_pkg.sv
// ----------------------------------------------------------------------------
// bnf_pkg: shared types and constants of the biquad notch filter
// Sample, coefficient and accumulator widths, the register map and the
// per-channel history record.
// ----------------------------------------------------------------------------
`default_nettype none

package bnf_pkg;

  // channel count and coefficient scaling
  localparam int CHANNELS       = 2;
  localparam int COEF_FRAC_BITS = 16;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int CHBIT_W  = 1;
  localparam int PROD_W   = COEF_W + SAMPLE_W;

  // history index width, at least one bit
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // accumulator wide enough for five products and for the sat compare
  localparam int ACC_W_SUM = PROD_W + 3;
  localparam int ACC_W_SAT = COEF_FRAC_BITS + SAMPLE_W + 1;
  localparam int ACC_W     = (ACC_W_SUM > ACC_W_SAT) ? ACC_W_SUM : ACC_W_SAT;
  localparam int QUO_W     = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [QUO_W-1:0] SAMPLE_MAX = QUO_W'(32767);
  localparam logic signed [QUO_W-1:0] SAMPLE_MIN = QUO_W'(-32768);

  // register map
  localparam int REG_IDX_W = 3;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FF_NOW      = 3'd0,
    REG_FF_ONE_BACK = 3'd1,
    REG_FF_TWO_BACK = 3'd2,
    REG_FB_ONE_BACK = 3'd3,
    REG_FB_TWO_BACK = 3'd4
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] FF_NOW_RESET = 18'sh10000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [CH_IDX_W-1:0]        ch_idx_t;

  typedef struct packed {
    coef_t ff_now;
    coef_t ff_one_back;
    coef_t ff_two_back;
    coef_t fb_one_back;
    coef_t fb_two_back;
  } coef_set_t;

  // one channel's history: last two inputs and last two outputs
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } hist_t;

  // history memory access request
  typedef struct packed {
    logic    rd_en;
    ch_idx_t rd_addr;
    logic    wr_en;
    ch_idx_t wr_addr;
  } mem_req_t;

  // channel tag to history slot, clamped to the last channel
  function automatic ch_idx_t chan_index(input logic [CHBIT_W-1:0] ch);
    ch_idx_t idx;
    if (int'(ch) >= CHANNELS) begin
      idx = CH_IDX_W'(CHANNELS - 1);
    end else begin
      idx = CH_IDX_W'(ch);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### design/bnf_ifaces.sv
// ----------------------------------------------------------------------------
// bnf channel interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

// input sample channel
interface bnf_sample_if;
  logic                             valid;
  logic                             ready;
  logic [bnf_pkg::CHBIT_W-1:0]      channel;
  logic signed [bnf_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output channel, output sample_in, input ready);
  modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// filtered result channel
interface bnf_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [bnf_pkg::SAMPLE_W-1:0] sample_out;
  logic [bnf_pkg::CHBIT_W-1:0]      out_channel;

  modport source (output valid, output sample_out, output out_channel, input ready);
  modport sink   (input valid, input sample_out, input out_channel, output ready);
endinterface

`default_nettype wire

### design/bnf_hist_mem.sv
// ----------------------------------------------------------------------------
// bnf_hist_mem: per-channel history memory
// One write port and one registered read port; entries read as zero until
// first written after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_hist_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bnf_pkg::mem_req_t req,
  input  wire bnf_pkg::hist_t    wr_data,
  output bnf_pkg::hist_t         rd_data
);

  bnf_pkg::hist_t          mem [bnf_pkg::CHANNELS];
  logic [bnf_pkg::CHANNELS-1:0] vld_r;
  bnf_pkg::hist_t          rd_q_r;
  logic                    rd_vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // registered read, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q_r   <= mem[req.rd_addr];
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

### design/bnf_mac.sv
// ----------------------------------------------------------------------------
// bnf_mac: biquad multiply and accumulate
// Five registered products, then sum, round half up, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_mac (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire bnf_pkg::coef_set_t coef,
  input  wire bnf_pkg::sample_t   x,
  input  wire bnf_pkg::hist_t     hist,
  output bnf_pkg::sample_t        y
);

  logic signed [bnf_pkg::PROD_W-1:0] prod_r [5];
  logic signed [bnf_pkg::PROD_W-1:0] prod_nxt [5];
  logic signed [bnf_pkg::ACC_W-1:0]  acc;
  logic signed [bnf_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [bnf_pkg::QUO_W-1:0]  quo;

  // products
  always_comb begin
    prod_nxt[0] = coef.ff_now      * x;
    prod_nxt[1] = coef.ff_one_back * hist.x1;
    prod_nxt[2] = coef.ff_two_back * hist.x2;
    prod_nxt[3] = coef.fb_one_back * hist.y1;
    prod_nxt[4] = coef.fb_two_back * hist.y2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // full-width sum, round half up, floor shift
  always_comb begin
    acc = bnf_pkg::ACC_W'(prod_r[0]) + bnf_pkg::ACC_W'(prod_r[1])
        + bnf_pkg::ACC_W'(prod_r[2]) - bnf_pkg::ACC_W'(prod_r[3])
        - bnf_pkg::ACC_W'(prod_r[4]);
    acc_rnd = acc + bnf_pkg::ROUND_HALF;
    quo     = acc_rnd[bnf_pkg::ACC_W-1:bnf_pkg::COEF_FRAC_BITS];
  end

  // saturate to the sample range
  always_comb begin
    priority if (quo > bnf_pkg::SAMPLE_MAX) begin
      y = bnf_pkg::SAMPLE_MAX[bnf_pkg::SAMPLE_W-1:0];
    end else if (quo < bnf_pkg::SAMPLE_MIN) begin
      y = bnf_pkg::SAMPLE_MIN[bnf_pkg::SAMPLE_W-1:0];
    end else begin
      y = quo[bnf_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/biquad_notch_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_notch_filter_unit: multi-channel direct form I biquad
// Filters tagged 16-bit samples with per-channel history in a small memory.
// ----------------------------------------------------------------------------
// Each transfer on in_ch yields one transfer on out_ch, in order. The result
// passes the history read register, the product registers and the output
// register, fed by sum/saturate. Samples of different channels are taken
// one per cycle while out_ch does not stall; a sample of the same channel as
// the one just taken waits until that one leaves the read stage, because of
// the feedback loop (history read, multiply stage, sum/saturate and history
// write-back). A stalled out_ch holds the whole pipeline. The history memory
// reads as zero after reset, so no clearing pass is needed. Coefficients are
// written via cfg_* while the filter is idle, which only the user ensures.
`default_nettype none

module biquad_notch_filter_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  bnf_sample_if.sink                            in_ch,
  bnf_result_if.source                          out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [bnf_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [bnf_pkg::COEF_W-1:0]       cfg_wdata
);

  bnf_pkg::coef_set_t coef_r;

  // pipeline control
  logic              adv;
  logic              in_xfer;
  bnf_pkg::ch_idx_t  in_idx;

  // read stage
  logic                        s1_valid_r;
  bnf_pkg::ch_idx_t            s1_ch_r;
  logic [bnf_pkg::CHBIT_W-1:0] s1_chbit_r;
  bnf_pkg::sample_t            s1_x_r;
  bnf_pkg::hist_t              s1_hist;

  // multiply stage
  logic                        s2_valid_r;
  bnf_pkg::ch_idx_t            s2_ch_r;
  logic [bnf_pkg::CHBIT_W-1:0] s2_chbit_r;
  bnf_pkg::hist_t              s2_hist_r;
  bnf_pkg::sample_t            s2_y;

  // write-back forwarding
  logic              wb_valid_r;
  bnf_pkg::ch_idx_t  wb_ch_r;
  bnf_pkg::hist_t    wb_data_r;

  // memory access
  bnf_pkg::mem_req_t mem_req;
  bnf_pkg::hist_t    mem_wr_data;
  bnf_pkg::hist_t    mem_rd_data;

  // output register
  logic                        out_valid_r;
  bnf_pkg::sample_t            out_sample_r;
  logic [bnf_pkg::CHBIT_W-1:0] out_chbit_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.ff_now      <= bnf_pkg::FF_NOW_RESET;
      coef_r.ff_one_back <= '0;
      coef_r.ff_two_back <= '0;
      coef_r.fb_one_back <= '0;
      coef_r.fb_two_back <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bnf_pkg::REG_FF_NOW:      coef_r.ff_now      <= cfg_wdata;
        bnf_pkg::REG_FF_ONE_BACK: coef_r.ff_one_back <= cfg_wdata;
        bnf_pkg::REG_FF_TWO_BACK: coef_r.ff_two_back <= cfg_wdata;
        bnf_pkg::REG_FB_ONE_BACK: coef_r.fb_one_back <= cfg_wdata;
        bnf_pkg::REG_FB_TWO_BACK: coef_r.fb_two_back <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance when the output register is free; hold off a same-channel
  // sample while its predecessor is still in the read stage
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_idx      = bnf_pkg::chan_index(in_ch.channel);
  assign in_ch.ready = adv && !(s1_valid_r && (s1_ch_r == in_idx));
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // history memory requests
  always_comb begin
    mem_req.rd_en   = in_xfer;
    mem_req.rd_addr = in_idx;
    mem_req.wr_en   = adv && s2_valid_r;
    mem_req.wr_addr = s2_ch_r;
    mem_wr_data     = '{x1: s2_hist_r.x1, x2: s2_hist_r.x2, y1: s2_y, y2: s2_hist_r.y2};
  end

  bnf_hist_mem u_hist_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // read stage: take the last write when it hit this channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r    <= in_idx;
      s1_chbit_r <= in_ch.channel;
      s1_x_r     <= in_ch.sample_in;
    end
  end

  assign s1_hist = (wb_valid_r && (wb_ch_r == s1_ch_r)) ? wb_data_r : mem_rd_data;

  // multiply stage
  bnf_mac u_mac (
    .clk  (clk),
    .en   (adv && s1_valid_r),
    .coef (coef_r),
    .x    (s1_x_r),
    .hist (s1_hist),
    .y    (s2_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_ch_r      <= s1_ch_r;
      s2_chbit_r   <= s1_chbit_r;
      s2_hist_r.x1 <= s1_x_r;
      s2_hist_r.x2 <= s1_hist.x1;
      s2_hist_r.y1 <= s1_hist.y1;
      s2_hist_r.y2 <= s1_hist.y1;
    end
  end

  // last history write, for a read that overlapped it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (mem_req.wr_en) begin
      wb_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      wb_ch_r   <= s2_ch_r;
      wb_data_r <= mem_wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_sample_r <= s2_y;
      out_chbit_r  <= s2_chbit_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_sample_r;
  assign out_ch.out_channel = out_chbit_r;

`ifndef NO_ASSERTIONS
  // a sample never enters while one of its own channel is in the read stage
  a_no_same_ch_follow: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !(s1_valid_r && (s1_ch_r == in_idx)))
    else $error("same-channel sample accepted behind read stage");

  // asserts that the read and multiply stages never hold the same channel
  a_stage_ch_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r) |-> (s1_ch_r != s2_ch_r))
    else $error("read and multiply stages hold the same channel");

  // a history write-back always delivers a result next cycle
  a_wb_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |=> (out_valid_r && (wb_ch_r == $past(s2_ch_r))))
    else $error("write-back without a result");
`endif

endmodule

`default_nettype wire
